>>> rtl/core/gift64_pkg.sv
// shared constants, types and round functions of the gift-64 cipher core
package gift64_pkg;

	localparam int BLOCK_W       = 64;
	localparam int KEY_W         = 128;
	localparam int RKEY_W        = 32;
	localparam int RC_W          = 6;
	localparam int ROUND_MAX     = 28;
	localparam int ROUND_DEFAULT = 28;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} gift64_reg_t;

	// word passed from one round cell to the next
	typedef struct packed {
		logic               valid;
		logic               opcode;
		logic [BLOCK_W-1:0] data;
	} gift64_stage_t;

	localparam logic [3:0] SBOX_FWD [16] = '{
		4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
		4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
	};
	localparam logic [3:0] SBOX_INV [16] = '{
		4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
		4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5
	};

	// destination of bit i under the forward bit permutation
	function automatic logic [5:0] perm_pos(input int i);
		int q;
		int r;
		q = i / 16;
		r = i % 16;
		return 6'(4 * q + 16 * ((3 * (r / 4) + (r % 4)) % 4) + (r % 4));
	endfunction

	function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] x);
		logic [BLOCK_W-1:0] y;
		for (int i = 0; i < BLOCK_W / 4; i++) begin
			y[4*i +: 4] = SBOX_FWD[x[4*i +: 4]];
		end
		return y;
	endfunction

	function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] x);
		logic [BLOCK_W-1:0] y;
		for (int i = 0; i < BLOCK_W / 4; i++) begin
			y[4*i +: 4] = SBOX_INV[x[4*i +: 4]];
		end
		return y;
	endfunction

	function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] x);
		logic [BLOCK_W-1:0] y;
		for (int i = 0; i < BLOCK_W; i++) begin
			y[perm_pos(i)] = x[i];
		end
		return y;
	endfunction

	function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] x);
		logic [BLOCK_W-1:0] y;
		for (int i = 0; i < BLOCK_W; i++) begin
			y[i] = x[perm_pos(i)];
		end
		return y;
	endfunction

	// round constant after idx+1 lfsr steps from zero
	function automatic logic [RC_W-1:0] round_const(input int idx);
		logic [RC_W-1:0] c;
		c = '0;
		for (int r = 0; r < ROUND_MAX; r++) begin
			if (r <= idx) begin
				c = {c[4:0], c[5] ^ c[4] ^ 1'b1};
			end
		end
		return c;
	endfunction

	// round key {u, v} of round idx, pure rewiring of the key
	function automatic logic [RKEY_W-1:0] round_key(input logic [KEY_W-1:0] key, input int idx);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [15:0] k0;
		logic [15:0] k1;
		lo = key[63:0];
		hi = key[127:64];
		for (int r = 0; r < ROUND_MAX; r++) begin
			if (r < idx) begin
				k0 = lo[15:0];
				k1 = lo[31:16];
				lo = {hi[31:0], lo[63:32]};
				hi = {k1[1:0], k1[15:2], k0[11:0], k0[15:12], hi[63:32]};
			end
		end
		return lo[31:0];
	endfunction

	function automatic logic [BLOCK_W-1:0] add_round(input logic [BLOCK_W-1:0] x,
			input logic [RKEY_W-1:0] rk, input logic [RC_W-1:0] rc);
		logic [BLOCK_W-1:0] y;
		y = x;
		for (int i = 0; i < 16; i++) begin
			y[4*i+1] = y[4*i+1] ^ rk[16+i];
			y[4*i]   = y[4*i] ^ rk[i];
		end
		y[63] = ~y[63];
		y[23] = y[23] ^ rc[5];
		y[19] = y[19] ^ rc[4];
		y[15] = y[15] ^ rc[3];
		y[11] = y[11] ^ rc[2];
		y[7]  = y[7] ^ rc[1];
		y[3]  = y[3] ^ rc[0];
		return y;
	endfunction

endpackage

>>> rtl/core/gift64_if.sv
// stream and configuration channel interfaces of the gift-64 cipher core
interface gift64_in_if
	import gift64_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [BLOCK_W-1:0] block_in;

	modport source (output valid, output opcode, output block_in, input ready);
	modport sink (input valid, input opcode, input block_in, output ready);
endinterface

interface gift64_out_if
	import gift64_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [BLOCK_W-1:0] block_out;

	modport source (output valid, output block_out, input ready);
	modport sink (input valid, input block_out, output ready);
endinterface

interface gift64_cfg_if
	import gift64_pkg::*;
();
	logic               valid;
	logic               ready;
	gift64_reg_t        index;
	logic [BLOCK_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/gift64_block_cipher_top.sv
// top level of the pipelined gift-64-128 block cipher core
// gift-64 with a 128-bit key: each input word carries an opcode (0 encrypt,
// 1 decrypt) and a 64-bit block, and each output word carries the 64-bit
// result. the rounds form a chain of ROUND_COUNT registered cells, one per
// round, so the core takes one block every cycle unless the output stalls
// and the chain is full; the last cell doubles as the output register. every
// cell has its own ready, so bubbles close up and new blocks keep entering
// while a finished result waits. the key sits in two registers written over
// the configuration channel (index 0 key_low with word k0 in bits 15:0, index
// 1 key_high with k4 in bits 15:0), both clear after reset; round keys are
// plain rewiring of the key and round constants are fixed per cell. the key
// is only to be written while no block is in flight.
module gift64_block_cipher_top
	import gift64_pkg::*;
#(
	parameter int ROUND_COUNT = ROUND_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	gift64_in_if.sink    blk_in,
	gift64_out_if.source blk_out,
	gift64_cfg_if.sink   cfg
);

	logic [63:0]   key_lo_q;
	logic [63:0]   key_hi_q;
	logic [KEY_W-1:0] key;

	// chain links: word and ready between neighbouring cells
	gift64_stage_t chain_word [ROUND_COUNT+1];
	logic          chain_ready [ROUND_COUNT+1];

	// key registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KEY_LOW:  key_lo_q <= cfg.data;
				REG_KEY_HIGH: key_hi_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign key = {key_hi_q, key_lo_q};

	// input word enters the first cell
	assign chain_word[0] = '{valid: blk_in.valid, opcode: blk_in.opcode,
		data: blk_in.block_in};
	assign blk_in.ready  = chain_ready[0];

	for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
		gift64_cell #(
			.ROUND_COUNT (ROUND_COUNT),
			.ROUND_IDX   (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.up_word  (chain_word[g]),
			.up_ready (chain_ready[g]),
			.dn_word  (chain_word[g+1]),
			.dn_ready (chain_ready[g+1])
		);
	end

	// last cell holds the result word
	assign blk_out.valid     = chain_word[ROUND_COUNT].valid;
	assign blk_out.block_out = chain_word[ROUND_COUNT].data;
	assign chain_ready[ROUND_COUNT] = blk_out.ready;

`ifndef SYNTHESIS
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!blk_out.valid |-> blk_in.ready)
		else $error("input blocked with empty output");
	a_key_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.valid |=> $stable(key_lo_q) && $stable(key_hi_q))
		else $error("key changed without a write");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		blk_out.valid && !blk_out.ready |=> blk_out.valid)
		else $error("result word dropped while stalled");
`endif

endmodule

>>> rtl/core/gift64_cell.sv
// one registered gift-64 round, forward or inverse, in the round chain
module gift64_cell
	import gift64_pkg::*;
#(
	parameter int ROUND_COUNT = ROUND_DEFAULT,
	parameter int ROUND_IDX   = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [KEY_W-1:0]  key,
	input  gift64_stage_t     up_word,
	output logic              up_ready,
	output gift64_stage_t     dn_word,
	input  logic              dn_ready
);

	// inverse rounds run in reverse order along the chain
	localparam int DEC_IDX = ROUND_COUNT - 1 - ROUND_IDX;
	localparam logic [RC_W-1:0] RC_ENC = round_const(ROUND_IDX);
	localparam logic [RC_W-1:0] RC_DEC = round_const(DEC_IDX);

	logic                valid_q;
	logic                opcode_q;
	logic [BLOCK_W-1:0]  data_q;
	logic [RKEY_W-1:0]   rk_enc;
	logic [RKEY_W-1:0]   rk_dec;
	logic [BLOCK_W-1:0]  enc_res;
	logic [BLOCK_W-1:0]  dec_res;

	assign rk_enc  = round_key(key, ROUND_IDX);
	assign rk_dec  = round_key(key, DEC_IDX);
	assign enc_res = add_round(perm_fwd(sub_fwd(up_word.data)), rk_enc, RC_ENC);
	assign dec_res = sub_inv(perm_inv(add_round(up_word.data, rk_dec, RC_DEC)));

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_word.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_word.valid) begin
			opcode_q <= up_word.opcode;
			data_q   <= up_word.opcode ? dec_res : enc_res;
		end
	end

	assign dn_word = '{valid: valid_q, opcode: opcode_q, data: data_q};

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !dn_ready |=> valid_q && $stable(data_q) && $stable(opcode_q))
		else $error("stalled word changed in round cell");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		up_word.valid && up_ready |=> valid_q)
		else $error("accepted word lost in round cell");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && dn_ready && !up_word.valid |=> !valid_q)
		else $error("word repeated by round cell");
`endif

endmodule

>>> test/gift64_block_cipher_check.sv
// watches the gift-64 channels, predicts every result block and compares it with the core's output
module gift64_block_cipher_check
	import gift64_pkg::*;
#(
	parameter int ROUNDS = ROUND_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	gift64_in_if  blk_in,
	gift64_out_if blk_out,
	gift64_cfg_if cfg,
	output int    fail_count,
	output int    outstanding
);

	// s-box tables, nibble n of the table is the image of n
	localparam logic [63:0] SBOX_TABLE     = 64'he805_7bd2_93f6_c4a1;
	localparam logic [63:0] SBOX_TABLE_INV = 64'h5f93_a17e_b4c2_680d;
	localparam int REPORT_LIMIT = 100;

	logic [63:0] key_lo;
	logic [63:0] key_hi;
	logic [63:0] pending_blocks [$];
	int mismatches;

	function automatic logic [63:0] nibble_sub(input logic [63:0] x, input logic [63:0] tbl);
		logic [63:0] y;
		for (int n = 0; n < 16; n++) begin
			y[4*n +: 4] = tbl[4*x[4*n +: 4] +: 4];
		end
		return y;
	endfunction

	// where bit i lands under the forward bit permutation
	function automatic logic [5:0] bit_dest(input logic [5:0] i);
		logic [1:0] lane;
		lane = i[1:0] - i[3:2];
		return {lane, i[5:4], i[1:0]};
	endfunction

	function automatic logic [63:0] mix_round_key(input logic [63:0] x, input logic [31:0] rk,
			input logic [5:0] rc);
		logic [63:0] y;
		y = x;
		for (int n = 0; n < 16; n++) begin
			y[4*n+1] = y[4*n+1] ^ rk[16+n];
			y[4*n]   = y[4*n] ^ rk[n];
		end
		for (int n = 0; n < 6; n++) begin
			y[4*n+3] = y[4*n+3] ^ rc[n];
		end
		y[63] = ~y[63];
		return y;
	endfunction

	function automatic logic [63:0] gift64_crypt(input logic decrypt, input logic [63:0] blk,
			input logic [63:0] klo, input logic [63:0] khi);
		logic [31:0] rkey [ROUNDS];
		logic [5:0]  rconst [ROUNDS];
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] x;
		logic [63:0] y;
		logic [15:0] w0;
		logic [15:0] w1;
		logic [5:0]  lfsr;
		lo = klo;
		hi = khi;
		lfsr = '0;
		// key schedule and constant lfsr
		for (int r = 0; r < ROUNDS; r++) begin
			w0 = lo[15:0];
			w1 = lo[31:16];
			rkey[r] = {w1, w0};
			lfsr = {lfsr[4:0], ~(lfsr[5] ^ lfsr[4])};
			rconst[r] = lfsr;
			lo = {hi[31:0], lo[63:32]};
			hi = {w1[1:0], w1[15:2], w0[11:0], w0[15:12], hi[63:32]};
		end
		x = blk;
		if (!decrypt) begin
			for (int r = 0; r < ROUNDS; r++) begin
				x = nibble_sub(x, SBOX_TABLE);
				for (int i = 0; i < 64; i++) begin
					y[bit_dest(6'(i))] = x[i];
				end
				x = mix_round_key(y, rkey[r], rconst[r]);
			end
		end else begin
			for (int r = ROUNDS - 1; r >= 0; r--) begin
				x = mix_round_key(x, rkey[r], rconst[r]);
				for (int i = 0; i < 64; i++) begin
					y[i] = x[bit_dest(6'(i))];
				end
				x = nibble_sub(y, SBOX_TABLE_INV);
			end
		end
		return x;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			key_lo = '0;
			key_hi = '0;
			pending_blocks.delete();
			mismatches = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (blk_out.valid && blk_out.ready) begin
				if (pending_blocks.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected block_out: expected none, got %h",
							$time, blk_out.block_out);
				end else begin
					want = pending_blocks.pop_front();
					if (blk_out.block_out !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: block_out mismatch: expected %h, got %h",
								$time, want, blk_out.block_out);
					end
				end
			end
			if (blk_in.valid && blk_in.ready)
				pending_blocks.push_back(gift64_crypt(blk_in.opcode, blk_in.block_in,
					key_lo, key_hi));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_KEY_LOW: key_lo = cfg.data;
					REG_KEY_HIGH: key_hi = cfg.data;
					default: ;
				endcase
			end
			fail_count <= mismatches;
			outstanding <= pending_blocks.size();
		end
	end

endmodule

>>> test/gift64_block_cipher_top_tb.sv
// stimulus and verdict for the gift-64-128 block cipher core
module gift64_block_cipher_top_tb;
	import gift64_pkg::*;

	localparam int HALF_PERIOD      = 10;
	localparam int RESET_CYCLES     = 10;
	localparam int WATCHDOG_LIMIT   = 1000;
	// a little over the pipeline depth
	localparam int SETTLE_CYCLES    = 40;
	localparam int PHASE_COUNT      = 8;
	localparam int BLOCKS_PER_PHASE = 200;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} cipher_op_t;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   idle_cycles;
	int   fail_count;
	int   outstanding;

	gift64_in_if  blk_in ();
	gift64_out_if blk_out ();
	gift64_cfg_if cfg ();

	gift64_block_cipher_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.blk_in  (blk_in),
		.blk_out (blk_out),
		.cfg     (cfg)
	);

	gift64_block_cipher_check cipher_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.blk_in      (blk_in),
		.blk_out     (blk_out),
		.cfg         (cfg),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		blk_out.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog: ends the run after too long with no word moving on any channel
	always @(posedge clk) begin
		if ((blk_in.valid && blk_in.ready) || (blk_out.valid && blk_out.ready) ||
				(cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("gift64_block_cipher_top_tb failed");
			$finish;
		end
	end

	// offer one block, with random idle cycles in front of it, and hold it until taken
	task automatic send_block(input cipher_op_t op, input logic [63:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			blk_in.valid <= 1'b0;
			@(posedge clk);
		end
		blk_in.valid    <= 1'b1;
		blk_in.opcode   <= op;
		blk_in.block_in <= data;
		@(posedge clk);
		while (!blk_in.ready) @(posedge clk);
	endtask

	// stop offering and wait for every predicted block to come out
	task automatic drain;
		blk_in.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input gift64_reg_t idx, input logic [63:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// key writes only happen with the pipeline empty
	task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
		drain;
		write_reg(REG_KEY_LOW, lo);
		write_reg(REG_KEY_HIGH, hi);
	endtask

	// random block: mostly uniform, sometimes an edge pattern
	function automatic logic [63:0] pick_block();
		logic [63:0] one_hot;
		one_hot = 64'd1 << $urandom_range(63);
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return ~one_hot;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		logic [63:0] phase_lo;
		logic [63:0] phase_hi;
		blk_in.valid    <= 1'b0;
		blk_in.opcode   <= OP_ENCRYPT;
		blk_in.block_in <= '0;
		cfg.valid       <= 1'b0;
		cfg.index       <= REG_KEY_LOW;
		cfg.data        <= '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// all-zero key straight out of reset
		send_block(OP_ENCRYPT, '0);
		send_block(OP_DECRYPT, '0);
		send_block(OP_ENCRYPT, '1);
		send_block(OP_DECRYPT, 64'h8000_0000_0000_0001);

		// directed blocks under an uneven key: extreme and alternating patterns both ways
		load_key(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
		send_block(OP_ENCRYPT, '0);
		send_block(OP_DECRYPT, '0);
		send_block(OP_ENCRYPT, '1);
		send_block(OP_DECRYPT, '1);
		send_block(OP_ENCRYPT, 64'h5555_5555_5555_5555);
		send_block(OP_DECRYPT, 64'haaaa_aaaa_aaaa_aaaa);
		send_block(OP_ENCRYPT, 64'h8000_0000_0000_0001);
		send_block(OP_DECRYPT, 64'h0000_0000_0000_0001);
		send_block(OP_ENCRYPT, 64'h0123_4567_89ab_cdef);
		send_block(OP_DECRYPT, 64'h0123_4567_89ab_cdef);

		// random phases: idle pattern cycles through four modes, key changes every phase
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin phase_lo = '1; phase_hi = '1; end
				1: begin phase_lo = '0; phase_hi = '1; end
				2: begin phase_lo = '1; phase_hi = '0; end
				4: begin
					phase_lo = 64'h5555_5555_5555_5555;
					phase_hi = 64'haaaa_aaaa_aaaa_aaaa;
				end
				default: begin
					phase_lo = {$urandom, $urandom};
					phase_hi = {$urandom, $urandom};
				end
			endcase
			load_key(phase_lo, phase_hi);
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
				// halfway through, let the pipeline run dry before carrying on
				if (n == BLOCKS_PER_PHASE / 2)
					drain;
				send_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT, pick_block());
			end
		end

		// final settle: nothing may arrive once all predictions are met
		drain;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("gift64_block_cipher_top_tb passed");
		end else begin
			$display("gift64_block_cipher_top_tb failed");
		end
		$finish;
	end

endmodule
